>>> rtl/core/dsr_pkg.sv
// Shared types, constants and a helper function of the depth subpacket reassembler.
`default_nettype none

package dsr_pkg;

    localparam int unsigned SUBPACKET_BYTES = 298496;
    localparam int unsigned FOOTER_BYTES    = 32;

    localparam int LEN_W      = 19;
    localparam int SUM_W      = LEN_W + 1;
    localparam int SEQ_W      = 32;
    localparam int SUB_W      = 4;
    localparam int CAP_W      = 24;
    localparam int DEST_W     = SUB_W + LEN_W;
    localparam int MASK_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [CAP_W-1:0]     CAPACITY_RESET = CAP_W'(2984960);
    localparam logic [MASK_W-1:0]    COMPLETE_MASK  = MASK_W'(16'h03ff);
    localparam logic [SEQ_W-1:0]     LOSS_INTERVAL  = SEQ_W'(30);
    localparam logic [SUM_W-1:0]     FOUND_SUM      = SUM_W'(SUBPACKET_BYTES + FOOTER_BYTES);
    localparam logic [SUM_W-1:0]     SUB_LIMIT      = SUM_W'(SUBPACKET_BYTES);
    localparam logic [LEN_W-1:0]     SUB_FULL       = LEN_W'(SUBPACKET_BYTES);

    localparam logic [REG_IDX_W-1:0] REG_FRAME_CAPACITY = REG_IDX_W'(0);

    localparam logic [STATUS_W-1:0] ST_ACCUMULATING = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RESYNC       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LEN_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STORED       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd5;

    typedef struct packed {
        logic [LEN_W-1:0] chunk_length;
        logic [SEQ_W-1:0] footer_sequence;
        logic [SUB_W-1:0] footer_subsequence;
        logic [LEN_W-1:0] footer_length;
        logic [SEQ_W-1:0] footer_timestamp;
        logic             consumer_ready;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [CAP_W-1:0]       copy_dest_offset;
        logic [LEN_W-1:0]       copy_src_offset;
        logic [LEN_W-1:0]       copy_bytes;
        logic                   frame_emitted;
        logic [SEQ_W-1:0]       frame_sequence;
        logic [SEQ_W-1:0]       frame_timestamp;
        logic                   frame_incomplete;
        logic                   frame_skipped;
        logic                   loss_report_valid;
        logic signed [SEQ_W-1:0] lost_frames;
    } t_out_item;

    // Divisibility by 30: even, and divisible by 15 (hex digit sum modulo 15).
    function automatic logic div_by_30(input logic [SEQ_W-1:0] v);
        logic [6:0] s;
        logic [4:0] s2;
        logic [3:0] s3;
        s  = 7'(v[3:0]) + 7'(v[7:4]) + 7'(v[11:8]) + 7'(v[15:12])
           + 7'(v[19:16]) + 7'(v[23:20]) + 7'(v[27:24]) + 7'(v[31:28]);
        s2 = 5'(s[6:4]) + 5'(s[3:0]);
        s3 = 4'(s2[4]) + s2[3:0];
        return !v[0] && ((s3 == 4'h0) || (s3 == 4'hf));
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/dsr_cfg_regs.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module dsr_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dsr_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [dsr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [dsr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output logic      [dsr_pkg::CAP_W-1:0]        o_frame_capacity
);
    import dsr_pkg::*;

    logic [CAP_W-1:0]     r_frame_capacity;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_capacity <= CAPACITY_RESET;
        end else if (wr_en && (reg_idx == REG_FRAME_CAPACITY)) begin
            r_frame_capacity <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_CAPACITY: prdata = APB_DATA_W'(r_frame_capacity);
            default:            prdata = '0;
        endcase
    end

    assign o_frame_capacity = r_frame_capacity;

endmodule

`default_nettype wire

>>> rtl/core/dsr_step.sv
// Reassembly state and the single-pass update that produces one result per transaction.
`default_nettype none

module dsr_step (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_advance,
    input  wire dsr_pkg::t_in_item           i_item,
    input  wire logic [dsr_pkg::CAP_W-1:0]   i_frame_capacity,
    output dsr_pkg::t_out_item               o_result
);
    import dsr_pkg::*;

    logic [LEN_W-1:0]  r_fill, n_fill;
    logic [SEQ_W-1:0]  r_cur, n_cur;
    logic              r_cur_div30, n_cur_div30;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic [SEQ_W-1:0]  r_pc, n_pc;

    logic [SUM_W-1:0]  sum;
    logic              found;
    logic [DEST_W-1:0] dest;
    logic              pc_wrap;
    logic [SEQ_W-1:0]  pc_inc;
    logic [SEQ_W-1:0]  diff;
    logic              report;
    logic [MASK_W-1:0] mask_base;
    t_out_item         res;

    assign sum     = SUM_W'(r_fill) + SUM_W'(i_item.chunk_length);
    assign found   = (sum == FOUND_SUM);
    assign dest    = DEST_W'(i_item.footer_subsequence) * DEST_W'(i_item.footer_length);
    assign pc_wrap = (r_pc == '1);
    assign pc_inc  = r_pc + SEQ_W'(1);
    assign diff    = pc_wrap ? '0 : (r_cur + ~r_pc);
    assign report  = (r_cur_div30 && (diff != '0)) || (!diff[SEQ_W-1] && (diff >= LOSS_INTERVAL));

    always_comb begin
        res         = '0;
        n_fill      = r_fill;
        n_cur       = r_cur;
        n_cur_div30 = r_cur_div30;
        n_mask      = r_mask;
        n_pc        = r_pc;
        mask_base   = r_mask;
        if (i_item.chunk_length == '0) begin
            res.status = ST_RESYNC;
            n_fill     = '0;
        end else if (!found) begin
            if (sum > SUB_LIMIT) begin
                res.status = ST_OVERSIZE;
                n_fill     = '0;
            end else begin
                res.status = ST_ACCUMULATING;
                n_fill     = sum[LEN_W-1:0];
            end
        end else if (i_item.footer_length != SUB_FULL) begin
            res.status = ST_LEN_MISMATCH;
            n_fill     = '0;
        end else begin
            n_fill = '0;
            if (r_cur != i_item.footer_sequence) begin
                res.frame_sequence = r_cur;
                if (r_mask == COMPLETE_MASK) begin
                    if (i_item.consumer_ready) begin
                        res.frame_emitted   = 1'b1;
                        res.frame_timestamp = i_item.footer_timestamp;
                        n_pc                = pc_wrap ? r_cur : pc_inc;
                        if (report) begin
                            res.loss_report_valid = 1'b1;
                            res.lost_frames       = diff;
                            n_pc                  = r_cur;
                        end
                    end else begin
                        res.frame_skipped = 1'b1;
                    end
                end else begin
                    res.frame_incomplete = 1'b1;
                end
                n_cur       = i_item.footer_sequence;
                n_cur_div30 = div_by_30(i_item.footer_sequence);
                mask_base   = '0;
            end
            n_mask = mask_base | (MASK_W'(1) << i_item.footer_subsequence);
            if (CAP_W'(dest) > i_frame_capacity) begin
                res.status = ST_OUT_OF_RANGE;
            end else begin
                res.status           = ST_STORED;
                res.copy_dest_offset = CAP_W'(dest);
                res.copy_src_offset  = SUB_FULL - i_item.footer_length;
                res.copy_bytes       = i_item.footer_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_cur       <= '0;
            r_cur_div30 <= 1'b1;
            r_mask      <= '0;
            r_pc        <= '1;
        end else if (i_advance) begin
            r_fill      <= n_fill;
            r_cur       <= n_cur;
            r_cur_div30 <= n_cur_div30;
            r_mask      <= n_mask;
            r_pc        <= n_pc;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

>>> rtl/core/depth_subpacket_reassembler_core.sv
// Top level of the depth subpacket reassembler: channels, pipeline registers and checks.
//
// Usage: each input transaction on i_in_data carries one transfer descriptor (its byte
// length and the decoded footer fields). Every input transaction produces exactly one
// result transaction on o_out_data, in order. A transfer length of zero resynchronizes
// the subpacket fill level.
// Both channels use valid and stall; a transaction moves at a rising edge where valid
// is high and stall is low. The frame_capacity register is written through the APB
// port at byte address 0. The user must write it only while no transaction is in
// flight; the block itself does not enforce this. A descriptor is captured in the
// input register, and its result is loaded into the output register when the output
// register can move. Throughput is one transaction per cycle while the receiver does
// not stall, set by the single-pass state update between the two registers.
// Reset clears the valid flags of both pipeline registers, resets the reassembly
// state, and restores frame_capacity to its reset value.
// When the receiver stalls, the result holds in the output register and one more
// descriptor may wait in the input register; further input is stalled until the
// output moves.
`default_nettype none

module depth_subpacket_reassembler_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire dsr_pkg::t_in_item                i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output dsr_pkg::t_out_item                    o_out_data,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dsr_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [dsr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [dsr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    import dsr_pkg::*;

    logic             r_in_valid;
    t_in_item         r_in_item;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic             out_busy;
    logic             advance;
    logic             in_accept;
    logic [CAP_W-1:0] frame_capacity;
    t_out_item        step_result;

    assign out_busy   = r_out_valid && i_out_stall;
    assign advance    = r_in_valid && !out_busy;
    assign o_in_stall = r_in_valid && out_busy;
    assign in_accept  = i_in_valid && !o_in_stall;

    dsr_cfg_regs u_cfg_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_frame_capacity (frame_capacity)
    );

    dsr_step u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_item           (r_in_item),
        .i_frame_capacity (frame_capacity),
        .o_result         (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    a_in_stall_only_when_out_blocked: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall)
    ) else $error("input stalled while the output register can move");

    a_frame_outcome_exclusive: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_out_data.frame_emitted, o_out_data.frame_incomplete,
                                  o_out_data.frame_skipped})
    ) else $error("more than one frame outcome in one result");

    a_loss_report_needs_emit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.loss_report_valid) |-> o_out_data.frame_emitted
    ) else $error("loss report without an emitted frame");

    a_result_follows_pending_item: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_busy) |=> o_out_valid
    ) else $error("pending descriptor advanced without producing a result");

endmodule

`default_nettype wire
